[hw/rtl/linear_setpoint_ramp_macros.svh]
// ----------------------------------------------------------------------------
// linear_setpoint_ramp_macros.svh
// Assertion macros for the setpoint ramp RTL.
// ----------------------------------------------------------------------------
`ifndef LINEAR_SETPOINT_RAMP_MACROS_SVH
`define LINEAR_SETPOINT_RAMP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising edge out of reset
`define LSR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LSR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LSR_ASSERT_IMP(label, ante, cons, msg)
`define LSR_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[hw/rtl/lsr_pkg.sv]
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared constants for the linear setpoint ramp.
// ----------------------------------------------------------------------------
package lsr_pkg;

    localparam int DEF_VALUE_BITS    = 16;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int STEP_COUNT_BITS   = 16;

    // Ramps shorter than this finish on the start item
    localparam logic [STEP_COUNT_BITS-1:0] MIN_RAMP_STEPS = 16'd2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

endpackage

[hw/rtl/linear_setpoint_ramp.sv]
// ----------------------------------------------------------------------------
// linear_setpoint_ramp
// Linear ramp generator with a fixed-point accumulator and a serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries cmd, begin_value, stop_value
//   and step_count. A start item (cmd = 0) loads a ramp and returns nothing.
//   A next item (cmd = 1) returns one item on the output channel
//   (out_valid / out_stall): ramp_value and done_res.
//   Next items are taken one per cycle while in_stall is low; each result shows up the cycle after
//   the item is accepted, from a single output register.
//   A start item with step_count of 2 or more runs a restoring divider that
//   retires one quotient bit per cycle; in_stall is high while it runs.
//   Shorter ramps load without the divider.
//   When the receiver stalls with a result waiting, in_stall rises and the
//   result holds until taken.
//   Reset clears the ramp to zero with done set, so next items return 0
//   with done_res high until a start item arrives.
// ----------------------------------------------------------------------------
`include "linear_setpoint_ramp_macros.svh"

module linear_setpoint_ramp #(
    parameter int VALUE_BITS    = lsr_pkg::DEF_VALUE_BITS,
    parameter int FRACTION_BITS = lsr_pkg::DEF_FRACTION_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic [VALUE_BITS-1:0]                begin_value,
    input  logic [VALUE_BITS-1:0]                stop_value,
    input  logic [lsr_pkg::STEP_COUNT_BITS-1:0]  step_count,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [VALUE_BITS-1:0]                ramp_value,
    output logic                                 done_res
);

    import lsr_pkg::*;

    localparam int ACC_BITS = VALUE_BITS + FRACTION_BITS;
    localparam int CNT_BITS = $clog2(ACC_BITS + 1);
    localparam int SCB      = STEP_COUNT_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic                 state_reg, state_next;
    logic [ACC_BITS-1:0]  acc_reg, acc_next;
    logic [ACC_BITS-1:0]  step_reg, step_next;
    logic [SCB-1:0]       steps_left_reg, steps_left_next;
    logic                 down_reg, down_next;
    logic [VALUE_BITS-1:0] target_reg, target_next;
    logic                 finished_reg, finished_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [ACC_BITS-1:0]  quot_reg, quot_next;
    logic [SCB-1:0]       rem_reg, rem_next;
    logic [SCB-1:0]       divisor_reg, divisor_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] ramp_value_reg, ramp_value_next;
    logic                 done_reg, done_next;

    logic                 in_acc;
    logic                 out_acc;
    logic [VALUE_BITS-1:0] diff;
    logic [SCB:0]         rem_shift;
    logic [SCB-1:0]       rem_sub;
    logic                 rem_ge;
    logic [SCB-1:0]       steps_dec;

    assign in_stall  = (state_reg == ST_DIV) || (out_valid_reg && out_stall);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;

    assign out_valid  = out_valid_reg;
    assign ramp_value = ramp_value_reg;
    assign done_res   = done_reg;

    assign diff = (begin_value < stop_value) ? (stop_value - begin_value)
                                             : (begin_value - stop_value);

    // Divider step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, quot_reg[ACC_BITS-1]};
    assign rem_sub   = rem_shift[SCB-1:0] - divisor_reg;
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});

    assign steps_dec = steps_left_reg - SCB'(1);

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        step_next       = step_reg;
        steps_left_next = steps_left_reg;
        down_next       = down_reg;
        target_next     = target_reg;
        finished_next   = finished_reg;
        cnt_next        = cnt_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        out_valid_next  = out_valid_reg;
        ramp_value_next = ramp_value_reg;
        done_next       = done_reg;

        if (out_acc)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && cmd == CMD_START)
                begin
                    target_next = stop_value;
                    if (step_count < MIN_RAMP_STEPS)
                    begin
                        acc_next        = {stop_value, FRACTION_BITS'(0)};
                        steps_left_next = '0;
                        step_next       = '0;
                        down_next       = 1'b0;
                        finished_next   = 1'b1;
                    end
                    else
                    begin
                        down_next       = !(begin_value < stop_value);
                        steps_left_next = step_count;
                        acc_next        = {begin_value, FRACTION_BITS'(0)};
                        finished_next   = 1'b0;
                        quot_next       = {diff, FRACTION_BITS'(0)};
                        rem_next        = '0;
                        divisor_next    = step_count - SCB'(1);
                        cnt_next        = CNT_BITS'(ACC_BITS);
                        state_next      = ST_DIV;
                    end
                end
                else if (in_acc && cmd == CMD_NEXT)
                begin
                    out_valid_next  = 1'b1;
                    ramp_value_next = acc_reg[ACC_BITS-1:FRACTION_BITS];
                    if (steps_left_reg == '0)
                    begin
                        finished_next = 1'b1;
                        done_next     = 1'b1;
                    end
                    else
                    begin
                        steps_left_next = steps_dec;
                        done_next       = finished_reg;
                        if (steps_dec == '0)
                        begin
                            // snap to the exact end value on the last step
                            acc_next        = {target_reg, FRACTION_BITS'(0)};
                            finished_next   = 1'b1;
                            ramp_value_next = target_reg;
                            done_next       = 1'b1;
                        end
                        else if (down_reg)
                        begin
                            acc_next = acc_reg - step_reg;
                        end
                        else
                        begin
                            acc_next = acc_reg + step_reg;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                quot_next = {quot_reg[ACC_BITS-2:0], rem_ge};
                rem_next  = rem_ge ? rem_sub : rem_shift[SCB-1:0];
                cnt_next  = cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    step_next  = {quot_reg[ACC_BITS-2:0], rem_ge};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            acc_reg        <= '0;
            step_reg       <= '0;
            steps_left_reg <= '0;
            down_reg       <= 1'b0;
            target_reg     <= '0;
            finished_reg   <= 1'b1;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            step_reg       <= step_next;
            steps_left_reg <= steps_left_next;
            down_reg       <= down_next;
            target_reg     <= target_next;
            finished_reg   <= finished_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg       <= quot_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        ramp_value_reg <= ramp_value_next;
        done_reg       <= done_next;
    end

    `LSR_ASSERT_NXT(a_start_enters_div,
        in_acc && cmd == CMD_START && step_count >= MIN_RAMP_STEPS,
        state_reg == ST_DIV, "long ramp start did not enter the divider")

    `LSR_ASSERT_IMP(a_empty_counter_finished,
        steps_left_reg == '0, finished_reg, "step counter empty but ramp not finished")

    `LSR_ASSERT_IMP(a_rem_below_divisor,
        state_reg == ST_DIV, rem_reg < divisor_reg, "divider remainder out of range")

    `LSR_ASSERT_NXT(a_next_gives_result,
        in_acc && cmd == CMD_NEXT, out_valid_reg, "next item produced no result")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_setpoint_ramp. Start and next items go in
// through the input channel with random gaps. A software copy of the ramp
// (16.16 accumulator, step from a truncating divide, down-counter) predicts
// each next result. Every result is checked field by field as it is taken.
// Covered: directed extremes, equal ends, short ramps, the longest step
// count, restart mid-ramp, back-pressure and random ramp sequences.
// ----------------------------------------------------------------------------
module tb;
    import lsr_pkg::*;

    localparam int VB          = DEF_VALUE_BITS;
    localparam int FB          = DEF_FRACTION_BITS;
    localparam int AB          = VB + FB;
    localparam int NB          = STEP_COUNT_BITS;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_GOAL   = 1250;
    localparam int TAIL_CYCLES = 2 * AB + 8;

    typedef struct packed {
        logic [VB-1:0] value;
        logic          done;
    } ramp_result_t;

    logic          clk         = 1'b0;
    logic          rst_n       = 1'b0;
    logic          in_valid    = 1'b0;
    logic          cmd         = CMD_NEXT;
    logic [VB-1:0] begin_value = '0;
    logic [VB-1:0] stop_value  = '0;
    logic [NB-1:0] step_count  = '0;
    logic          out_stall   = 1'b0;
    logic          in_stall;
    logic          out_valid;
    logic [VB-1:0] ramp_value;
    logic          done_res;

    // Ramp state of the prediction
    logic [AB-1:0] acc_q      = '0;
    logic [AB-1:0] step_q     = '0;
    logic [NB-1:0] left_q     = '0;
    logic          down_q     = 1'b0;
    logic [VB-1:0] target_q   = '0;
    logic          finished_q = 1'b1;

    ramp_result_t ramp_results[$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  items_sent  = 0;
    int  rx_hold_req = 0;
    bit  tx_idle_en  = 1'b1;
    bit  rx_idle_en  = 1'b1;

    linear_setpoint_ramp dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .begin_value (begin_value),
        .stop_value  (stop_value),
        .step_count  (step_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ramp_value  (ramp_value),
        .done_res    (done_res)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_error(input string msg);
        error_count++;
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Advance the ramp copy by one item and queue the result a next item yields
    task automatic step_ramp(input logic c, input logic [VB-1:0] bv,
                             input logic [VB-1:0] ev, input logic [NB-1:0] nv);
        logic [VB-1:0] diff;
        logic [VB-1:0] val;
        ramp_result_t  res;
        if (c == CMD_START)
        begin
            target_q = ev;
            if (nv < MIN_RAMP_STEPS)
            begin
                acc_q      = {ev, {FB{1'b0}}};
                left_q     = '0;
                step_q     = '0;
                down_q     = 1'b0;
                finished_q = 1'b1;
            end
            else
            begin
                down_q     = !(bv < ev);
                diff       = down_q ? bv - ev : ev - bv;
                left_q     = nv;
                step_q     = {diff, {FB{1'b0}}} / {{(AB-NB){1'b0}}, nv - 1'b1};
                acc_q      = {bv, {FB{1'b0}}};
                finished_q = 1'b0;
            end
        end
        else
        begin
            val = acc_q[AB-1:FB];
            if (left_q == 0)
                finished_q = 1'b1;
            else
            begin
                left_q--;
                // Snap the last step to the exact end value
                if (left_q == 0)
                begin
                    acc_q      = {target_q, {FB{1'b0}}};
                    finished_q = 1'b1;
                    val        = target_q;
                end
                else if (down_q)
                    acc_q = acc_q - step_q;
                else
                    acc_q = acc_q + step_q;
            end
            res.value = val;
            res.done  = finished_q;
            ramp_results.push_back(res);
        end
    endtask

    task automatic send_item(input logic c, input logic [VB-1:0] bv,
                             input logic [VB-1:0] ev, input logic [NB-1:0] nv);
        int gap;
        @(negedge clk);
        cmd         <= c;
        begin_value <= bv;
        stop_value  <= ev;
        step_count  <= nv;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        step_ramp(c, bv, ev, nv);
        items_sent++;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_next();
        send_item(CMD_NEXT, VB'($urandom_range(0, 65535)), VB'($urandom_range(0, 65535)),
                  NB'($urandom_range(0, 65535)));
    endtask

    task automatic send_nexts(input int count);
        repeat (count) send_next();
    endtask

    // Drop valid and hold until every queued result has been taken
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (ramp_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_idle_after_reset();
        send_nexts(2);
    endtask

    task automatic test_extremes();
        send_item(CMD_START, 16'h0000, 16'hFFFF, 16'd2);
        send_nexts(3);
        send_item(CMD_START, 16'hFFFF, 16'h0000, 16'd3);
        send_nexts(3);
    endtask

    task automatic test_equal_ends();
        send_item(CMD_START, 16'h1234, 16'h1234, 16'd4);
        send_nexts(2);
    endtask

    // Also interrupts the equal-ends ramp mid-way
    task automatic test_short_ramps();
        send_item(CMD_START, 16'hA5A5, 16'h5A5A, 16'd0);
        send_next();
        send_item(CMD_START, 16'h0F0F, 16'hF0F0, 16'd1);
        send_next();
    endtask

    task automatic test_longest_count();
        send_item(CMD_START, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_nexts(2);
    endtask

    task automatic test_back_pressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_item(CMD_START, 16'd1000, 16'd40, 16'd12);
        rx_hold_req = 120;
        send_nexts(16);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_drain_pause();
        send_item(CMD_START, 16'd7, 16'd300, 16'd5);
        send_nexts(3);
        wait_results_drained();
        send_nexts(4);
    endtask

    task automatic test_random_ramps(input int item_goal);
        logic [VB-1:0] bv;
        logic [VB-1:0] ev;
        logic [NB-1:0] nv;
        int            nexts;
        int            r;
        while (items_sent < item_goal)
        begin
            tx_idle_en = ($urandom_range(0, 5) != 0);
            rx_idle_en = ($urandom_range(0, 5) != 0);
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(($urandom_range(0, 1) == 0) ? CMD_START : CMD_NEXT,
                              VB'($urandom_range(0, 65535)), VB'($urandom_range(0, 65535)),
                              NB'($urandom_range(0, 65535)));
            end
            else
            begin
                bv = VB'($urandom_range(0, 65535));
                r  = $urandom_range(0, 9);
                if (r == 0)
                    ev = bv;
                else if (r == 1)
                    ev = bv + VB'($urandom_range(0, 7));
                else if (r == 2)
                    ev = bv - VB'($urandom_range(0, 7));
                else if (r == 3)
                begin
                    bv = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                    ev = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                end
                else
                    ev = VB'($urandom_range(0, 65535));
                r = $urandom_range(0, 99);
                if (r < 70)
                    nv = NB'($urandom_range(0, 24));
                else if (r < 93)
                    nv = NB'($urandom_range(25, 120));
                else
                    nv = NB'($urandom_range(0, 65535));
                // Mostly walk the whole ramp into the done hold, else cut it short
                if (nv <= 120 && $urandom_range(0, 2) != 0)
                    nexts = nv + $urandom_range(0, 3);
                else
                    nexts = $urandom_range(0, 24);
                send_item(CMD_START, bv, ev, nv);
                send_nexts(nexts);
            end
            if ($urandom_range(0, 40) == 0)
                wait_results_drained();
        end
    endtask

    // Receiver: random stalls, plus long hold-offs on request
    initial
    begin
        int hold_left;
        int stall_left;
        int hold_seen;
        hold_left  = 0;
        stall_left = 0;
        hold_seen  = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req != hold_seen)
            begin
                hold_left = rx_hold_req;
                hold_seen = rx_hold_req;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_stall() - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Result checker
    initial
    begin
        ramp_result_t exp_res;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (ramp_results.size() == 0)
                    report_error($sformatf("unexpected result: value %0d done %0b",
                                           ramp_value, done_res));
                else
                begin
                    exp_res = ramp_results.pop_front();
                    if (ramp_value !== exp_res.value)
                        report_error($sformatf("ramp_value %0d, expected %0d",
                                               ramp_value, exp_res.value));
                    if (done_res !== exp_res.done)
                        report_error($sformatf("done_res %0b, expected %0b",
                                               done_res, exp_res.done));
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_after_reset();
        test_extremes();
        test_equal_ends();
        test_short_ramps();
        test_longest_count();
        test_back_pressure();
        test_drain_pause();
        test_random_ramps(ITEM_GOAL);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
